### hw/rtl/fsrc_pkg.sv
// Shared types, codes and defaults for the fault site reachability check.
`timescale 1ns / 1ps
`default_nettype none
package fsrc_pkg;

    // Default sizes of the netlist stores and the command queue
    localparam int NETS_DEF   = 4096;
    localparam int NODES_DEF  = 4096;
    localparam int EDGES_DEF  = 16384;
    localparam int QDEPTH_DEF = 2;

    // Fixed field widths
    localparam int REQ_W  = 3;
    localparam int IDX_W  = 15;
    localparam int NET_W  = 13;
    localparam int LINK_W = 15;
    localparam int CNT_W  = 13;
    localparam int EP_W   = 8;

    // Request codes on the input word
    localparam logic [REQ_W-1:0] REQ_NODE  = 3'd0;
    localparam logic [REQ_W-1:0] REQ_OFFS  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_TGT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_FLAG  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_QUERY = 3'd4;

    // Command codes between front and back
    localparam logic [2:0] OP_NODE  = 3'd0;
    localparam logic [2:0] OP_OFFS  = 3'd1;
    localparam logic [2:0] OP_TGT   = 3'd2;
    localparam logic [2:0] OP_FLAG  = 3'd3;
    localparam logic [2:0] OP_QUERY = 3'd4;
    localparam logic [2:0] OP_QZERO = 3'd5;

    typedef logic [5:0][NET_W-1:0] fsrc_ins_t;

    typedef struct packed {
        logic [REQ_W-1:0]  req_type;
        logic [IDX_W-1:0]  item_index;
        logic [NET_W-1:0]  out_net;
        logic [NET_W-1:0]  in_a;
        logic [NET_W-1:0]  in_b;
        logic [NET_W-1:0]  in_c;
        logic [NET_W-1:0]  in_d;
        logic [NET_W-1:0]  in_e;
        logic [NET_W-1:0]  in_f;
        logic [LINK_W-1:0] link_value;
        logic              observable_flag;
        logic              controllable_flag;
    } fsrc_in_t;

    typedef struct packed {
        logic observable_reach;
        logic reachable_from_source;
    } fsrc_out_t;

    typedef struct packed {
        logic [2:0]        op;
        logic              drv;
        logic [IDX_W-1:0]  idx;
        logic [NET_W-1:0]  out_net;
        fsrc_ins_t         ins;
        logic [LINK_W-1:0] link;
        logic              obs;
        logic              ctl;
    } fsrc_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } fsrc_qstat_t;

    typedef struct packed {
        logic clearing;
    } fsrc_stat_t;

endpackage
`default_nettype wire

### hw/rtl/fsrc_front.sv
// Front end: accepts input words, range checks them and turns them into commands.
`timescale 1ns / 1ps
`default_nettype none
module fsrc_front
    import fsrc_pkg::*;
#(
    parameter int NETS  = NETS_DEF,
    parameter int NODES = NODES_DEF,
    parameter int EDGES = EDGES_DEF
)
(
    input  wire fsrc_in_t    in_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [CNT_W-1:0] n_lim,
    input  wire fsrc_qstat_t qstat,
    input  wire fsrc_stat_t  bstat,
    output logic             push,
    output fsrc_cmd_t        cmd
);

    logic keep;

    assign in_ready = !qstat.full && !bstat.clearing;

    // Classify the word; out of range loads and unknown codes are dropped
    always_comb
    begin
        cmd.op      = OP_NODE;
        cmd.drv     = (32'(in_data.out_net) < 32'(n_lim));
        cmd.idx     = in_data.item_index;
        cmd.out_net = in_data.out_net;
        cmd.ins     = {in_data.in_f, in_data.in_e, in_data.in_d,
                       in_data.in_c, in_data.in_b, in_data.in_a};
        cmd.link    = in_data.link_value;
        cmd.obs     = in_data.observable_flag;
        cmd.ctl     = in_data.controllable_flag;
        keep        = 1'b0;
        case (in_data.req_type)
            REQ_NODE:
            begin
                cmd.op = OP_NODE;
                keep   = (32'(in_data.item_index) < NODES);
            end
            REQ_OFFS:
            begin
                cmd.op = OP_OFFS;
                keep   = (32'(in_data.item_index) <= NETS);
            end
            REQ_TGT:
            begin
                cmd.op = OP_TGT;
                keep   = (32'(in_data.item_index) < EDGES);
            end
            REQ_FLAG:
            begin
                cmd.op = OP_FLAG;
                keep   = (32'(in_data.item_index) < NETS);
            end
            REQ_QUERY:
            begin
                cmd.op = (32'(in_data.item_index) < 32'(n_lim)) ? OP_QUERY : OP_QZERO;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign push = in_valid && in_ready && keep;

endmodule
`default_nettype wire

### hw/rtl/fsrc_queue.sv
// Short command queue between the front end and the walk engine.
`timescale 1ns / 1ps
`default_nettype none
module fsrc_queue
    import fsrc_pkg::*;
#(
    parameter int DEPTH = QDEPTH_DEF
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire fsrc_cmd_t push_cmd,
    input  wire logic      pop,
    output fsrc_cmd_t      head,
    output fsrc_qstat_t    qstat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    fsrc_cmd_t         slot_reg [DEPTH];
    logic [AW-1:0]     wr_reg, wr_next;
    logic [AW-1:0]     rd_reg, rd_next;
    logic [CW-1:0]     cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == CW'(DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign head        = slot_reg[rd_reg];

    // Pointer and fill count
    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    // Payload slots
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

### hw/rtl/fsrc_back.sv
// Walk engine: netlist stores, load execution and forward/backward reachability walks.
`timescale 1ns / 1ps
`default_nettype none
module fsrc_back
    import fsrc_pkg::*;
#(
    parameter int NETS  = NETS_DEF,
    parameter int NODES = NODES_DEF,
    parameter int EDGES = EDGES_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic [CNT_W-1:0] n_lim,
    input  wire fsrc_cmd_t        cmd,
    input  wire fsrc_qstat_t      qstat,
    output logic                  pop,
    output fsrc_stat_t            bstat,
    output fsrc_out_t             out_data,
    output logic                  out_valid,
    input  wire logic             out_ready
);

    localparam int NW = $clog2(NETS);
    localparam int ND = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = $clog2(NETS + 1);
    localparam int EW = (EDGES > 1) ? $clog2(EDGES) : 1;

    localparam logic [4:0] S_CLR   = 5'd0;
    localparam logic [4:0] S_IDLE  = 5'd1;
    localparam logic [4:0] S_EP    = 5'd2;
    localparam logic [4:0] S_SCLR  = 5'd3;
    localparam logic [4:0] S_START = 5'd4;
    localparam logic [4:0] S_CHK0  = 5'd5;
    localparam logic [4:0] S_POP   = 5'd6;
    localparam logic [4:0] S_POPW  = 5'd7;
    localparam logic [4:0] S_RANGE = 5'd8;
    localparam logic [4:0] S_EDGE  = 5'd9;
    localparam logic [4:0] S_TW    = 5'd10;
    localparam logic [4:0] S_TCHK  = 5'd11;
    localparam logic [4:0] S_DRV   = 5'd12;
    localparam logic [4:0] S_NIN   = 5'd13;
    localparam logic [4:0] S_IN    = 5'd14;
    localparam logic [4:0] S_INW   = 5'd15;
    localparam logic [4:0] S_RES   = 5'd16;

    // Memories
    logic [EP_W-1:0]   seen_mem [NETS];
    logic [1:0]        flg_mem  [NETS];
    logic [ND:0]       drv_mem  [NETS];
    fsrc_ins_t         node_mem [NODES];
    logic [LINK_W-1:0] st_mem   [NETS + 1];
    logic [LINK_W-1:0] tgt_mem  [EDGES];
    logic [NW-1:0]     stk_mem  [NETS];

    logic [EP_W-1:0]   seen_q;
    logic [1:0]        flg_q;
    logic [ND:0]       drv_q;
    fsrc_ins_t         nin_q;
    logic [LINK_W-1:0] lo_q, hi_q, tgt_q;
    logic [NW-1:0]     stk_q;

    logic              seen_we, flg_we, drv_we, node_we, st_we, tgt_we, stk_we;
    logic [NW-1:0]     seen_wa, seen_ra, flg_wa, flg_ra, drv_wa, drv_ra, stk_wa, stk_ra;
    logic [EP_W-1:0]   seen_wd;
    logic [1:0]        flg_wd;
    logic [ND:0]       drv_wd;
    logic [ND-1:0]     node_wa, node_ra;
    fsrc_ins_t         node_wd;
    logic [SW-1:0]     st_wa, st_ra0, st_ra1;
    logic [LINK_W-1:0] st_wd, tgt_wd;
    logic [EW-1:0]     tgt_wa, tgt_ra;
    logic [NW-1:0]     stk_wd;

    // Control registers
    logic [4:0]        state_reg, state_next;
    logic [NW-1:0]     clr_reg, clr_next;
    logic [EP_W-1:0]   ep_reg, ep_next;
    logic [NW:0]       sp_reg, sp_next;
    logic [LINK_W-1:0] i_reg, i_next;
    logic [LINK_W-1:0] hi_reg, hi_next;
    logic [2:0]        k_reg, k_next;
    logic              bwd_reg, bwd_next;
    logic              ov_reg, ov_next;
    // Payload registers
    fsrc_ins_t         ins_reg, ins_next;
    logic [LINK_W-1:0] cur_reg, cur_next;
    logic [NW-1:0]     fault_reg, fault_next;
    logic              rf_reg, rf_next;
    logic              rb_reg, rb_next;
    fsrc_out_t         od_reg, od_next;

    logic [NET_W-1:0]  in_sel;
    logic              hit_bit;

    assign in_sel         = ins_reg[k_reg];
    assign hit_bit        = bwd_reg ? flg_q[0] : flg_q[1];
    assign bstat.clearing = (state_reg == S_CLR);
    assign pop            = (state_reg == S_IDLE) && !qstat.empty;
    assign out_valid      = ov_reg;
    assign out_data       = od_reg;

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        clr_next   = clr_reg;
        ep_next    = ep_reg;
        sp_next    = sp_reg;
        i_next     = i_reg;
        hi_next    = hi_reg;
        k_next     = k_reg;
        bwd_next   = bwd_reg;
        ins_next   = ins_reg;
        cur_next   = cur_reg;
        fault_next = fault_reg;
        rf_next    = rf_reg;
        rb_next    = rb_reg;
        ov_next    = ov_reg && !out_ready;
        od_next    = od_reg;

        seen_we = 1'b0; seen_wa = clr_reg; seen_wd = '0; seen_ra = NW'(cur_reg);
        flg_we  = 1'b0; flg_wa  = clr_reg; flg_wd  = '0; flg_ra  = NW'(cur_reg);
        drv_we  = 1'b0; drv_wa  = clr_reg; drv_wd  = '0; drv_ra  = stk_q;
        node_we = 1'b0; node_wa = ND'(cmd.idx); node_wd = cmd.ins;
        node_ra = drv_q[ND-1:0];
        st_we   = 1'b0; st_wa   = SW'(cmd.idx); st_wd = cmd.link;
        st_ra0  = SW'(stk_q); st_ra1 = SW'(32'(stk_q) + 1);
        tgt_we  = 1'b0; tgt_wa  = EW'(cmd.idx); tgt_wd = cmd.link;
        tgt_ra  = EW'(i_reg);
        stk_we  = 1'b0; stk_wa  = NW'(sp_reg); stk_wd = NW'(cur_reg);
        stk_ra  = NW'(sp_reg - 1'b1);

        case (state_reg)
            // Reset sweep over driver map, flags and seen marks
            S_CLR:
            begin
                seen_we  = 1'b1;
                flg_we   = 1'b1;
                drv_we   = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NW'(NETS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!qstat.empty)
                begin
                    case (cmd.op)
                        OP_NODE:
                        begin
                            node_we = 1'b1;
                            drv_we  = cmd.drv;
                            drv_wa  = NW'(cmd.out_net);
                            drv_wd  = {1'b1, ND'(cmd.idx)};
                        end
                        OP_OFFS:
                        begin
                            st_we = 1'b1;
                        end
                        OP_TGT:
                        begin
                            tgt_we = 1'b1;
                        end
                        OP_FLAG:
                        begin
                            flg_we = 1'b1;
                            flg_wa = NW'(cmd.idx);
                            flg_wd = {cmd.obs, cmd.ctl};
                        end
                        OP_QUERY:
                        begin
                            fault_next = NW'(cmd.idx);
                            bwd_next   = 1'b0;
                            state_next = S_EP;
                        end
                        OP_QZERO:
                        begin
                            rf_next    = 1'b0;
                            rb_next    = 1'b0;
                            state_next = S_RES;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            // New seen epoch per walk; sweep the marks when the tag wraps
            S_EP:
            begin
                if (ep_reg == '1)
                begin
                    clr_next   = '0;
                    state_next = S_SCLR;
                end
                else
                begin
                    ep_next    = ep_reg + 1'b1;
                    state_next = S_START;
                end
            end
            S_SCLR:
            begin
                seen_we  = 1'b1;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == NW'(NETS - 1))
                begin
                    ep_next    = EP_W'(1);
                    state_next = S_START;
                end
            end
            S_START:
            begin
                seen_we    = 1'b1;
                seen_wa    = fault_reg;
                seen_wd    = ep_reg;
                stk_we     = 1'b1;
                stk_wa     = '0;
                stk_wd     = fault_reg;
                sp_next    = (NW+1)'(1);
                flg_ra     = fault_reg;
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                if (hit_bit)
                begin
                    if (bwd_reg)
                    begin
                        rb_next    = 1'b1;
                        state_next = S_RES;
                    end
                    else
                    begin
                        rf_next    = 1'b1;
                        bwd_next   = 1'b1;
                        state_next = S_EP;
                    end
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_POP:
            begin
                if (sp_reg == '0)
                begin
                    if (bwd_reg)
                    begin
                        rb_next    = 1'b0;
                        state_next = S_RES;
                    end
                    else
                    begin
                        rf_next    = 1'b0;
                        bwd_next   = 1'b1;
                        state_next = S_EP;
                    end
                end
                else
                begin
                    sp_next    = sp_reg - 1'b1;
                    state_next = S_POPW;
                end
            end
            S_POPW:
            begin
                state_next = bwd_reg ? S_DRV : S_RANGE;
            end
            // Forward walk over the fanout list
            S_RANGE:
            begin
                i_next     = lo_q;
                hi_next    = hi_q;
                state_next = S_EDGE;
            end
            S_EDGE:
            begin
                if ((i_reg < hi_reg) && (32'(i_reg) < EDGES))
                begin
                    state_next = S_TW;
                end
                else
                begin
                    state_next = S_POP;
                end
            end
            S_TW:
            begin
                cur_next = tgt_q;
                seen_ra  = NW'(tgt_q);
                flg_ra   = NW'(tgt_q);
                if (32'(tgt_q) >= 32'(n_lim))
                begin
                    i_next     = i_reg + 1'b1;
                    state_next = S_EDGE;
                end
                else
                begin
                    state_next = S_TCHK;
                end
            end
            S_TCHK:
            begin
                i_next     = i_reg + 1'b1;
                state_next = S_EDGE;
                if (seen_q != ep_reg)
                begin
                    seen_we = 1'b1;
                    seen_wa = NW'(cur_reg);
                    seen_wd = ep_reg;
                    if (flg_q[1])
                    begin
                        rf_next    = 1'b1;
                        bwd_next   = 1'b1;
                        state_next = S_EP;
                    end
                    else if (32'(sp_reg) < NETS)
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end
            end
            // Backward walk through the driver's inputs
            S_DRV:
            begin
                state_next = drv_q[ND] ? S_NIN : S_POP;
            end
            S_NIN:
            begin
                ins_next   = nin_q;
                k_next     = '0;
                state_next = S_IN;
            end
            S_IN:
            begin
                cur_next = LINK_W'(in_sel);
                seen_ra  = NW'(in_sel);
                flg_ra   = NW'(in_sel);
                if (k_reg == 3'd6)
                begin
                    state_next = S_POP;
                end
                else if (32'(in_sel) >= 32'(n_lim))
                begin
                    k_next = k_reg + 1'b1;
                end
                else
                begin
                    state_next = S_INW;
                end
            end
            S_INW:
            begin
                k_next     = k_reg + 1'b1;
                state_next = S_IN;
                if (seen_q != ep_reg)
                begin
                    seen_we = 1'b1;
                    seen_wa = NW'(cur_reg);
                    seen_wd = ep_reg;
                    if (flg_q[0])
                    begin
                        rb_next    = 1'b1;
                        state_next = S_RES;
                    end
                    else if (32'(sp_reg) < NETS)
                    begin
                        stk_we  = 1'b1;
                        sp_next = sp_reg + 1'b1;
                    end
                end
            end
            // Hand the answer to the output register
            S_RES:
            begin
                if (!ov_reg || out_ready)
                begin
                    ov_next                        = 1'b1;
                    od_next.observable_reach       = rf_reg;
                    od_next.reachable_from_source  = rb_reg;
                    state_next                     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLR;
            clr_reg   <= '0;
            ep_reg    <= '0;
            sp_reg    <= '0;
            i_reg     <= '0;
            hi_reg    <= '0;
            k_reg     <= '0;
            bwd_reg   <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            ep_reg    <= ep_next;
            sp_reg    <= sp_next;
            i_reg     <= i_next;
            hi_reg    <= hi_next;
            k_reg     <= k_next;
            bwd_reg   <= bwd_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ins_reg   <= ins_next;
        cur_reg   <= cur_next;
        fault_reg <= fault_next;
        rf_reg    <= rf_next;
        rb_reg    <= rb_next;
        od_reg    <= od_next;
    end

    // Memory ports, read data registered
    always_ff @(posedge clk)
    begin
        if (seen_we)
        begin
            seen_mem[seen_wa] <= seen_wd;
        end
        seen_q <= seen_mem[seen_ra];
    end

    always_ff @(posedge clk)
    begin
        if (flg_we)
        begin
            flg_mem[flg_wa] <= flg_wd;
        end
        flg_q <= flg_mem[flg_ra];
    end

    always_ff @(posedge clk)
    begin
        if (drv_we)
        begin
            drv_mem[drv_wa] <= drv_wd;
        end
        drv_q <= drv_mem[drv_ra];
    end

    always_ff @(posedge clk)
    begin
        if (node_we)
        begin
            node_mem[node_wa] <= node_wd;
        end
        nin_q <= node_mem[node_ra];
    end

    always_ff @(posedge clk)
    begin
        if (st_we)
        begin
            st_mem[st_wa] <= st_wd;
        end
        lo_q <= st_mem[st_ra0];
        hi_q <= st_mem[st_ra1];
    end

    always_ff @(posedge clk)
    begin
        if (tgt_we)
        begin
            tgt_mem[tgt_wa] <= tgt_wd;
        end
        tgt_q <= tgt_mem[tgt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_mem[stk_wa] <= stk_wd;
        end
        stk_q <= stk_mem[stk_ra];
    end

endmodule
`default_nettype wire

### hw/rtl/fault_site_reachability_check_top.sv
// Top level of the fault site reachability check: front end, command queue and walk engine.
`timescale 1ns / 1ps
`default_nettype none
// Loads a netlist word by word and answers reachability queries for a fault net.
// After reset the engine sweeps its driver map, flag and seen stores, one net a
// cycle; no input word is taken during that sweep. Load words are then executed
// by the engine from its idle state, and a two-entry queue lets the front end run
// ahead of the engine. A query runs a forward then a backward stack walk through
// stores with registered read data, popping nets and examining their fanout edges
// or driver inputs before the result hand-off. Seen marks use an 8-bit epoch tag,
// so every 255th walk adds a sweep of the seen marks.
module fault_site_reachability_check_top
    import fsrc_pkg::*;
#(
    parameter int NETS   = NETS_DEF,
    parameter int NODES  = NODES_DEF,
    parameter int EDGES  = EDGES_DEF,
    parameter int QDEPTH = QDEPTH_DEF
)
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire fsrc_in_t         in_data,
    input  wire logic             in_valid,
    output logic                  in_ready,
    output fsrc_out_t             out_data,
    output logic                  out_valid,
    input  wire logic             out_ready,
    input  wire logic [CNT_W-1:0] cfg_data,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready
);

    logic [CNT_W-1:0] net_total_reg;
    logic [CNT_W-1:0] n_lim;
    logic             push, pop;
    fsrc_cmd_t        push_cmd, head;
    fsrc_qstat_t      qstat;
    fsrc_stat_t       bstat;

    // Net count register and its clamp to the store size
    assign cfg_ready = 1'b1;
    assign n_lim     = (32'(net_total_reg) < NETS) ? net_total_reg : CNT_W'(NETS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            net_total_reg <= '0;
        end
        else if (cfg_valid)
        begin
            net_total_reg <= cfg_data;
        end
    end

    fsrc_front #(.NETS(NETS), .NODES(NODES), .EDGES(EDGES)) u_front (
        .in_data  (in_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .n_lim    (n_lim),
        .qstat    (qstat),
        .bstat    (bstat),
        .push     (push),
        .cmd      (push_cmd)
    );

    fsrc_queue #(.DEPTH(QDEPTH)) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    fsrc_back #(.NETS(NETS), .NODES(NODES), .EDGES(EDGES)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .n_lim     (n_lim),
        .cmd       (head),
        .qstat     (qstat),
        .pop       (pop),
        .bstat     (bstat),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready)
    );

    // No word is taken while the stores are being swept
    a_no_take_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        bstat.clearing |-> !in_ready)
        else $error("input taken during store sweep");

    // A waiting result is never dropped
    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result lost before hand-off");

    // Queue cannot be full and empty at once
    a_queue_sane: assert property (@(posedge clk) disable iff (!rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue state inconsistent");

    // Engine pops only from a non-empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("pop from empty queue");

endmodule
`default_nettype wire

### tb/sv/fault_site_reachability_check_top_tb.sv
// Self-checking testbench for the fault site reachability check top level.
`timescale 1ns / 1ps
module fault_site_reachability_check_top_tb;
    import fsrc_pkg::*;

    // Scoreboard: mirrors the netlist stores and predicts each query answer
    class reach_scoreboard;
        int  live_nets;
        bit  drv_ok[NETS_DEF];
        int  drv_node[NETS_DEF];
        int  node_in[NODES_DEF][6];
        int  fo_start[NETS_DEF+1];
        int  fo_tgt[EDGES_DEF];
        bit  obs_mark[NETS_DEF];
        bit  ctl_mark[NETS_DEF];
        bit  seen[NETS_DEF];
        int  walk_stk[NETS_DEF];
        int  sp;
        fsrc_out_t answer_q[$];
        int  mismatches;
        int  answers_checked;

        function void set_net_total(int v);
            live_nets = (v < NETS_DEF) ? v : NETS_DEF;
        endfunction

        function void clear_seen();
            foreach (seen[i])
                seen[i] = 1'b0;
            sp = 0;
        endfunction

        // forward walk over fanout, stops at first observable net
        function bit walk_fanout(int f);
            bit hit;
            int net;
            int t;
            clear_seen();
            seen[f] = 1'b1;
            walk_stk[0] = f;
            sp = 1;
            hit = obs_mark[f];
            while (sp > 0 && !hit) begin
                sp--;
                net = walk_stk[sp];
                for (int i = fo_start[net]; i < fo_start[net+1] && i < EDGES_DEF; i++) begin
                    t = fo_tgt[i];
                    if (t >= live_nets || seen[t])
                        continue;
                    seen[t] = 1'b1;
                    if (obs_mark[t]) begin
                        hit = 1'b1;
                        break;
                    end
                    if (sp < NETS_DEF) begin
                        walk_stk[sp] = t;
                        sp++;
                    end
                end
            end
            return hit;
        endfunction

        // backward walk through driver inputs, stops at first controllable net
        function bit walk_fanin(int f);
            bit hit;
            int net;
            int s;
            clear_seen();
            seen[f] = 1'b1;
            walk_stk[0] = f;
            sp = 1;
            hit = ctl_mark[f];
            while (sp > 0 && !hit) begin
                sp--;
                net = walk_stk[sp];
                if (!drv_ok[net])
                    continue;
                for (int k = 0; k < 6; k++) begin
                    s = node_in[drv_node[net]][k];
                    if (s >= live_nets || seen[s])
                        continue;
                    seen[s] = 1'b1;
                    if (ctl_mark[s]) begin
                        hit = 1'b1;
                        break;
                    end
                    if (sp < NETS_DEF) begin
                        walk_stk[sp] = s;
                        sp++;
                    end
                end
            end
            return hit;
        endfunction

        function void note_word(fsrc_in_t w);
            int idx;
            fsrc_out_t a;
            idx = int'(w.item_index);
            case (w.req_type)
                REQ_NODE: begin
                    if (idx < NODES_DEF) begin
                        node_in[idx][0] = int'(w.in_a);
                        node_in[idx][1] = int'(w.in_b);
                        node_in[idx][2] = int'(w.in_c);
                        node_in[idx][3] = int'(w.in_d);
                        node_in[idx][4] = int'(w.in_e);
                        node_in[idx][5] = int'(w.in_f);
                        if (int'(w.out_net) < live_nets) begin
                            drv_node[w.out_net] = idx;
                            drv_ok[w.out_net] = 1'b1;
                        end
                    end
                end
                REQ_OFFS:
                    if (idx <= NETS_DEF)
                        fo_start[idx] = int'(w.link_value);
                REQ_TGT:
                    if (idx < EDGES_DEF)
                        fo_tgt[idx] = int'(w.link_value);
                REQ_FLAG:
                    if (idx < NETS_DEF) begin
                        obs_mark[idx] = w.observable_flag;
                        ctl_mark[idx] = w.controllable_flag;
                    end
                REQ_QUERY: begin
                    a = '0;
                    if (idx < live_nets) begin
                        a.observable_reach      = walk_fanout(idx);
                        a.reachable_from_source = walk_fanin(idx);
                    end
                    answer_q.insert(answer_q.size(), a);
                end
                default: ;
            endcase
        endfunction

        function void report(string msg);
            if (mismatches < 10)
                $display("%t mismatch: %s", $realtime, msg);
            mismatches++;
        endfunction

        function void check_word(fsrc_out_t r);
            fsrc_out_t e;
            if (answer_q.size() == 0) begin
                report($sformatf("unexpected answer obs=%0b src=%0b",
                                 r.observable_reach, r.reachable_from_source));
                return;
            end
            e = answer_q.pop_front();
            answers_checked++;
            if (r.observable_reach !== e.observable_reach)
                report($sformatf("observable_reach exp %0b got %0b",
                                 e.observable_reach, r.observable_reach));
            if (r.reachable_from_source !== e.reachable_from_source)
                report($sformatf("reachable_from_source exp %0b got %0b",
                                 e.reachable_from_source, r.reachable_from_source));
        endfunction
    endclass

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    fsrc_in_t         in_data = '0;
    logic             in_valid = 1'b0;
    logic             in_ready;
    fsrc_out_t        out_data;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic [CNT_W-1:0] cfg_data = '0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;

    reach_scoreboard sb;
    bit  quiet_in;
    bit  quiet_out;
    int  n_eff;
    int  win_base;
    int  win_size;
    int  edge_pos[25];
    int  words_sent;
    int  settings_run;

    fault_site_reachability_check_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_data   (in_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_data  (out_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_data  (cfg_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Drive one input word, with a random gap before it
    task automatic send_word(fsrc_in_t w);
        int gap;
        gap = quiet_in ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_data  <= w;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        sb.note_word(w);
        words_sent++;
    endtask

    // Write the net total once the engine has drained
    task automatic write_net_total(int v);
        in_valid <= 1'b0;
        while (sb.answer_q.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_data  <= CNT_W'(v);
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 1'b0;
        sb.set_net_total(v);
        n_eff = sb.live_nets;
        settings_run++;
    endtask

    function automatic fsrc_in_t rand_word();
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        return raw[$bits(fsrc_in_t)-1:0];
    endfunction

    // keep walked nets inside the window whose fanout stores are written
    function automatic int safe_net(int v);
        if (v < n_eff && (v < win_base || v >= win_base + win_size))
            return win_base + $urandom_range(0, win_size - 1);
        return v;
    endfunction

    function automatic int win_net();
        return win_base + $urandom_range(0, win_size - 1);
    endfunction

    function automatic int pick_input();
        int r;
        r = $urandom_range(0, 9);
        if (r < 3)
            return NETS_DEF;
        if (r == 3)
            return 8191;
        if (r < 7)
            return $urandom_range(0, n_eff - 1);
        return win_net();
    endfunction

    function automatic fsrc_in_t node_word(int out_net);
        fsrc_in_t w;
        w = rand_word();
        w.req_type   = REQ_NODE;
        w.item_index = IDX_W'($urandom_range(0, NODES_DEF - 1));
        w.out_net    = NET_W'(out_net);
        w.in_a = NET_W'(pick_input());
        w.in_b = NET_W'(pick_input());
        w.in_c = NET_W'(pick_input());
        w.in_d = NET_W'(pick_input());
        w.in_e = NET_W'(pick_input());
        w.in_f = NET_W'(pick_input());
        return w;
    endfunction

    function automatic fsrc_in_t load_word(logic [REQ_W-1:0] req, int idx, int link);
        fsrc_in_t w;
        w = rand_word();
        w.req_type   = req;
        w.item_index = IDX_W'(idx);
        w.link_value = LINK_W'(link);
        return w;
    endfunction

    function automatic fsrc_in_t flag_word(int idx);
        fsrc_in_t w;
        w = load_word(REQ_FLAG, idx, $urandom);
        w.observable_flag   = ($urandom_range(0, 7) == 0);
        w.controllable_flag = ($urandom_range(0, 7) == 0);
        return w;
    endfunction

    function automatic fsrc_in_t query_word();
        fsrc_in_t w;
        w = rand_word();
        w.req_type = REQ_QUERY;
        if (win_size > 0 && $urandom_range(0, 3) != 0)
            w.item_index = IDX_W'(win_net());
        else
            w.item_index = IDX_W'(safe_net($urandom_range(0, 32767)));
        return w;
    endfunction

    // Words the block must ignore
    function automatic fsrc_in_t noise_word();
        fsrc_in_t w;
        w = rand_word();
        case ($urandom_range(0, 3))
            0: w.req_type = REQ_W'($urandom_range(32'(REQ_QUERY) + 1, 7));
            1: begin
                w.req_type   = REQ_OFFS;
                w.item_index = IDX_W'($urandom_range(NETS_DEF + 1, 32767));
            end
            2: begin
                w.req_type   = REQ_TGT;
                w.item_index = IDX_W'($urandom_range(EDGES_DEF, 32767));
            end
            default: begin
                w.req_type   = REQ_NODE;
                w.item_index = IDX_W'($urandom_range(NODES_DEF, 32767));
            end
        endcase
        return w;
    endfunction

    function automatic int tgt_value();
        if ($urandom_range(0, 9) < 8)
            return win_net();
        return safe_net($urandom_range(0, 32767));
    endfunction

    // One net total setting: build a fanout window, then mixed traffic
    task automatic run_setting(int nc);
        int top;
        int r;
        write_net_total(nc);
        quiet_in  = ($urandom_range(0, 3) == 0);
        quiet_out = ($urandom_range(0, 3) == 0);
        win_size = 0;
        win_base = 0;
        if (n_eff > 0)
        begin
            win_size = $urandom_range(1, (n_eff < 24) ? n_eff : 24);
            win_base = $urandom_range(0, n_eff - win_size);
            edge_pos[0] = ($urandom_range(0, 4) == 0) ? $urandom_range(16370, 16383)
                                                       : $urandom_range(0, 16000);
            for (int j = 0; j < win_size; j++)
                edge_pos[j+1] = edge_pos[j] + $urandom_range(0, 3);
            for (int j = 0; j <= win_size; j++)
                send_word(load_word(REQ_OFFS, win_base + j, edge_pos[j]));
            for (int i = edge_pos[0]; i < edge_pos[win_size] && i < EDGES_DEF; i++)
                send_word(load_word(REQ_TGT, i, tgt_value()));
            for (int j = 0; j < win_size; j++)
            begin
                send_word(flag_word(win_base + j));
                if ($urandom_range(0, 9) < 6)
                    send_word(node_word(win_base + j));
            end
        end
        top = (edge_pos[win_size] < EDGES_DEF) ? edge_pos[win_size] : EDGES_DEF;
        for (int k = 0; k < 50; k++)
        begin
            r = $urandom_range(0, 9);
            if (r < 5 || win_size == 0)
                send_word((r < 8) ? query_word() : noise_word());
            else if (r < 7)
                send_word(flag_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, 32767)
                                                                : win_net()));
            else if (r == 7)
                send_word(node_word(($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191)
                                                                : win_net()));
            else if (r == 8 && top > edge_pos[0])
                send_word(load_word(REQ_TGT, $urandom_range(edge_pos[0], top - 1),
                                    tgt_value()));
            else
                send_word(noise_word());
        end
    endtask

    // Result side: random stalls, each accepted word checked
    initial
    begin
        int st;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever
        begin
            st = quiet_out ? 0 : $urandom_range(0, 4);
            if (st > 0)
            begin
                out_ready <= 1'b0;
                repeat (st) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            sb.check_word(out_data);
        end
    end

    // Main sequence
    initial
    begin
        int plan[6] = '{0, 1, 8191, 4096, 4095, 2};
        int p;
        sb = new();
        sb.set_net_total(0);
        n_eff = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: zero nets, unknown requests, then a small hand-built netlist
        send_word(query_word());
        for (int u = 32'(REQ_QUERY) + 1; u <= 7; u++)
            send_word(load_word(REQ_W'(u), 0, 0));
        write_net_total(8);
        win_base = 0;
        win_size = 8;
        for (int j = 0; j <= 8; j++)
            send_word(load_word(REQ_OFFS, j, (j == 0) ? 0 : (j == 1) ? 2 : 3));
        send_word(load_word(REQ_TGT, 0, 1));
        send_word(load_word(REQ_TGT, 1, 2));
        send_word(load_word(REQ_TGT, 2, 3));
        send_word(load_word(REQ_OFFS, NETS_DEF + 1, 5));
        send_word(load_word(REQ_TGT, EDGES_DEF, 0));
        send_word('{req_type: REQ_FLAG, item_index: 3, observable_flag: 1'b1, default: '0});
        send_word('{req_type: REQ_FLAG, item_index: 5, controllable_flag: 1'b1, default: '0});
        send_word('{req_type: REQ_FLAG, item_index: NETS_DEF, observable_flag: 1'b1,
                    controllable_flag: 1'b1, default: '0});
        send_word('{req_type: REQ_NODE, item_index: NODES_DEF - 1, out_net: 2, in_a: 5,
                    in_b: NETS_DEF, in_c: NETS_DEF, in_d: NETS_DEF, in_e: NETS_DEF,
                    in_f: NETS_DEF, default: '0});
        send_word('{req_type: REQ_NODE, item_index: NODES_DEF, out_net: 1, in_a: 5,
                    default: '0});
        send_word('{req_type: REQ_NODE, item_index: 7, out_net: 9, in_a: 5, default: '0});
        send_word('{req_type: REQ_QUERY, item_index: 0, default: '0});
        send_word('{req_type: REQ_QUERY, item_index: 2, default: '0});
        send_word('{req_type: REQ_QUERY, item_index: 7, default: '0});
        send_word('{req_type: REQ_QUERY, item_index: 8, default: '0});
        send_word('{req_type: REQ_QUERY, item_index: 32767, default: '0});

        // Random settings until enough words have gone in
        p = 0;
        while (words_sent < 850)
        begin
            run_setting((p < 6) ? plan[p]
                        : ($urandom_range(0, 5) == 0) ? $urandom_range(300, 8191)
                                                       : $urandom_range(3, 300));
            p++;
        end

        in_valid <= 1'b0;
        while (sb.answer_q.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("Sent %0d words over %0d net total settings; %0d query answers checked.",
                 words_sent, settings_run, sb.answers_checked);
        if (sb.mismatches == 0)
            $display("PASS fault_site_reachability_check_top");
        else
            $display("FAIL fault_site_reachability_check_top");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000_000;
        $display("Timeout with %0d answers outstanding", sb.answer_q.size());
        $display("FAIL fault_site_reachability_check_top");
        $finish;
    end

endmodule
